// ----- rtl/core/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// psa_pkg
// shared widths, constants and types of the projected polygon area block
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int COORD_W    = 24;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int TERM_W     = PROD_W + 1;
    localparam int SUM_W      = 58;
    localparam int AREA_W     = SUM_W - 1;
    localparam int MAX_POINTS = 1024;
    localparam int MIN_POINTS = 3;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int NPLANES    = 3;

    localparam int IN_TDATA_W  = ((3 * COORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NPLANES * AREA_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    localparam int PL_YZ = 0;
    localparam int PL_XZ = 1;
    localparam int PL_XY = 2;

    localparam int USR_FEW = 0;
    localparam int USR_SAT = 1;

    localparam logic signed [SUM_W-1:0] SUM_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vtx_t;

    typedef struct packed {
        vtx_t cur;
        vtx_t prev;
        vtx_t first;
        logic last;
        logic cnt_ovf;
        logic too_few;
    } item_t;

endpackage

// ----- rtl/core/psa_front.sv -----
// ----------------------------------------------------------------------------
// psa_front
// vertex intake: tracks first and previous vertex and the vertex count,
// and classifies each vertex into an edge job for the back end
// ----------------------------------------------------------------------------
module psa_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [psa_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            q_full,
    output logic                            push,
    output psa_pkg::item_t                  push_item
);
    import psa_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_after;
    vtx_t             first_reg;
    vtx_t             prev_reg;
    vtx_t             cur;
    logic             empty_poly;
    logic             cnt_ovf;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        cur.x       = s_tdata[COORD_W-1:0];
        cur.y       = s_tdata[2*COORD_W-1:COORD_W];
        cur.z       = s_tdata[3*COORD_W-1:2*COORD_W];
        empty_poly  = (count_reg == '0);
        cnt_ovf     = (count_reg == CNT_W'(MAX_POINTS));
        count_after = cnt_ovf ? count_reg : count_reg + CNT_W'(1);
        count_next  = s_tlast ? '0 : count_after;

        // an edge from a vertex to itself adds nothing
        push_item.cur     = cur;
        push_item.prev    = empty_poly ? cur : prev_reg;
        push_item.first   = empty_poly ? cur : first_reg;
        push_item.last    = s_tlast;
        push_item.cnt_ovf = cnt_ovf;
        push_item.too_few = (count_after < CNT_W'(MIN_POINTS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            prev_reg <= cur;
            if (empty_poly)
            begin
                first_reg <= cur;
            end
        end
    end

endmodule

// ----- rtl/core/psa_queue.sv -----
// ----------------------------------------------------------------------------
// psa_queue
// short first-in first-out buffer of edge jobs between front and back end
// ----------------------------------------------------------------------------
module psa_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  psa_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output psa_pkg::item_t  pop_item
);
    import psa_pkg::*;

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign pop_valid = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/psa_back.sv -----
// ----------------------------------------------------------------------------
// psa_back
// shoelace pipeline: cross products, edge terms, saturating accumulation,
// closing edge, absolute value and the output register
// ----------------------------------------------------------------------------
module psa_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  psa_pkg::item_t                   q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [psa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [psa_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import psa_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] pos;
        logic signed [PROD_W-1:0] neg;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    clip;
    } sat_t;

    typedef struct packed {
        logic last;
        logic cnt_ovf;
        logic too_few;
    } flags_t;

    function automatic prod_t xprod(input logic signed [COORD_W-1:0] a1,
                                    input logic signed [COORD_W-1:0] b2,
                                    input logic signed [COORD_W-1:0] b1,
                                    input logic signed [COORD_W-1:0] a2);
        prod_t r;
        r.pos = PROD_W'(a1) * PROD_W'(b2);
        r.neg = PROD_W'(b1) * PROD_W'(a2);
        return r;
    endfunction

    function automatic sat_t sat_add(input logic signed [SUM_W-1:0]  s,
                                     input logic signed [TERM_W-1:0] t);
        logic signed [SUM_W:0] w;
        sat_t                  r;
        w = (SUM_W+1)'(s) + (SUM_W+1)'(t);
        r.clip = 1'b1;
        if (w > (SUM_W+1)'(SUM_LIMIT))
        begin
            r.sum = SUM_LIMIT;
        end
        else if (w < -(SUM_W+1)'(SUM_LIMIT))
        begin
            r.sum = -SUM_LIMIT;
        end
        else
        begin
            r.sum  = w[SUM_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    logic adv;

    // product stage
    logic   p_valid_reg;
    prod_t  pe_reg [NPLANES];
    prod_t  pk_reg [NPLANES];
    flags_t p_flags_reg;

    // term stage
    logic                     d_valid_reg;
    logic signed [TERM_W-1:0] de_reg [NPLANES];
    logic signed [TERM_W-1:0] dk_reg [NPLANES];
    flags_t                   d_flags_reg;

    // accumulators
    logic signed [SUM_W-1:0]  sum_reg  [NPLANES];
    logic signed [SUM_W-1:0]  sum_next [NPLANES];
    logic                     ovf_reg;
    logic                     ovf_next;
    sat_t                     acc      [NPLANES];
    logic                     acc_clip;

    // polygon closing stage
    logic                     a_valid_reg;
    logic signed [SUM_W-1:0]  as_reg [NPLANES];
    logic signed [TERM_W-1:0] ak_reg [NPLANES];
    logic                     a_ovf_reg;
    logic                     a_few_reg;
    sat_t                     cls    [NPLANES];
    logic                     cls_clip;

    // absolute value stage
    logic                     c_valid_reg;
    logic signed [SUM_W-1:0]  cs_reg [NPLANES];
    logic                     c_ovf_reg;
    logic                     c_few_reg;

    // output register
    logic                     o_valid_reg;
    logic [AREA_W-1:0]        area_reg [NPLANES];
    logic                     o_few_reg;
    logic                     o_sat_reg;
    logic [AREA_W-1:0]        area_next [NPLANES];

    assign adv   = !o_valid_reg || m_tready;
    assign q_pop = adv;

    always_comb
    begin
        acc_clip = 1'b0;
        cls_clip = 1'b0;
        for (int i = 0; i < NPLANES; i++)
        begin
            acc[i]   = sat_add(sum_reg[i], de_reg[i]);
            acc_clip = acc_clip | acc[i].clip;
            cls[i]   = sat_add(as_reg[i], ak_reg[i]);
            cls_clip = cls_clip | cls[i].clip;
            if (c_few_reg)
            begin
                area_next[i] = '0;
            end
            else if (cs_reg[i] < 0)
            begin
                area_next[i] = AREA_W'(-cs_reg[i]);
            end
            else
            begin
                area_next[i] = AREA_W'(cs_reg[i]);
            end
        end
        ovf_next = ovf_reg | acc_clip | d_flags_reg.cnt_ovf;
        for (int i = 0; i < NPLANES; i++)
        begin
            sum_next[i] = d_flags_reg.last ? '0 : acc[i].sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            for (int i = 0; i < NPLANES; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            p_valid_reg <= q_valid;
            d_valid_reg <= p_valid_reg;
            a_valid_reg <= d_valid_reg && d_flags_reg.last;
            c_valid_reg <= a_valid_reg;
            o_valid_reg <= c_valid_reg;
            if (d_valid_reg)
            begin
                ovf_reg <= d_flags_reg.last ? 1'b0 : ovf_next;
                for (int i = 0; i < NPLANES; i++)
                begin
                    sum_reg[i] <= sum_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pe_reg[PL_YZ] <= xprod(q_item.prev.y, q_item.cur.z, q_item.cur.y, q_item.prev.z);
            pe_reg[PL_XZ] <= xprod(q_item.prev.x, q_item.cur.z, q_item.cur.x, q_item.prev.z);
            pe_reg[PL_XY] <= xprod(q_item.cur.x, q_item.prev.y, q_item.cur.y, q_item.prev.x);
            pk_reg[PL_YZ] <= xprod(q_item.cur.y, q_item.first.z, q_item.first.y, q_item.cur.z);
            pk_reg[PL_XZ] <= xprod(q_item.cur.x, q_item.first.z, q_item.first.x, q_item.cur.z);
            pk_reg[PL_XY] <= xprod(q_item.first.x, q_item.cur.y, q_item.first.y, q_item.cur.x);
            p_flags_reg.last    <= q_item.last;
            p_flags_reg.cnt_ovf <= q_item.cnt_ovf;
            p_flags_reg.too_few <= q_item.too_few;

            for (int i = 0; i < NPLANES; i++)
            begin
                de_reg[i] <= TERM_W'(pe_reg[i].pos) - TERM_W'(pe_reg[i].neg);
                dk_reg[i] <= TERM_W'(pk_reg[i].pos) - TERM_W'(pk_reg[i].neg);
                as_reg[i] <= acc[i].sum;
                ak_reg[i] <= dk_reg[i];
                cs_reg[i] <= cls[i].sum;
                area_reg[i] <= area_next[i];
            end
            d_flags_reg <= p_flags_reg;
            a_ovf_reg   <= ovf_next;
            a_few_reg   <= d_flags_reg.too_few;
            c_ovf_reg   <= a_ovf_reg | cls_clip;
            c_few_reg   <= a_few_reg;
            o_few_reg   <= c_few_reg;
            o_sat_reg   <= c_ovf_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - NPLANES*AREA_W){1'b0}},
                       area_reg[PL_XY], area_reg[PL_XZ], area_reg[PL_YZ]};

    always_comb
    begin
        m_tuser          = '0;
        m_tuser[USR_FEW] = o_few_reg;
        m_tuser[USR_SAT] = o_sat_reg;
    end

endmodule

// ----- rtl/core/polygon_projected_area_shoelace.sv -----
// ----------------------------------------------------------------------------
// polygon_projected_area_shoelace
// doubled absolute polygon area projected on the yz, xz and xy planes
// ----------------------------------------------------------------------------
// Vertices enter one per transaction on the slave side (tlast marks the final
// vertex) and the block takes one vertex every clock cycle while its queue is
// not full. Each polygon gives one result transaction on the master side once
// its final vertex has passed the queue and the product, term, closing,
// absolute value and output stages. The accumulator does one saturating 58-bit
// add per plane per cycle unless the output stalls. A four-entry queue between
// intake and pipeline keeps the slave side open for a few vertices while the
// master side stalls. Areas are twice the true area, saturated at 2^57 - 1;
// too_few_points zeroes them for polygons of fewer than three vertices.
module polygon_projected_area_shoelace
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_x, point_y, point_z
    input  logic [psa_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // area_yz_doubled, area_xz_doubled, area_xy_doubled
    output logic [psa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // too_few_points, saturated
    output logic [psa_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import psa_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  q_pop;
    logic  q_valid;
    item_t q_item;

    psa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    psa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    psa_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/core/psa_checker.sv -----
// ----------------------------------------------------------------------------
// psa_checker
// port-level checks of the projected polygon area block
// ----------------------------------------------------------------------------
module psa_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [psa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic [psa_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import psa_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // short polygon gives zero areas
    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USR_FEW] |-> m_tdata == '0)
        else $error("areas not zero for short polygon");

    // padding bits above the three areas stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:NPLANES*AREA_W] == '0)
        else $error("padding bits set");

    // no result while or right after reset
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result during reset");

    // slave side ready once reset is released
    a_rdy: assert property (@(posedge clk)
        $rose(rst_n) |-> s_tready)
        else $error("slave side not ready after reset");

endmodule

bind polygon_projected_area_shoelace psa_checker u_psa_checker (.*);
